>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the timer table top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg
// Types, codes and sizes shared by the timer table modules.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS      = 8;
    localparam int TICK_WIDTH = 32;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int ACT_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int DELAY_W = 32;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SCAN  = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SLOT_W-1:0]  slot_id;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] period;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              fired;
        logic              status;
        logic              last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;
        logic ack;
        logic scan_start;
        logic cmp_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic is_ack;
        logic is_scan;
        logic out_free;
        logic cmp_done;
        logic mask_any;
    } stat_t;

endpackage

>>> hdl/mstt_in_if.sv
// ----------------------------------------------------------------------------
// mstt_in_if
// Valid/ready channel that carries one timer action item.
// ----------------------------------------------------------------------------
interface mstt_in_if;
    logic                          valid;
    logic                          ready;
    logic [mstt_pkg::ACT_W-1:0]    action;
    logic [mstt_pkg::SLOT_W-1:0]   slot_id;
    logic [mstt_pkg::DELAY_W-1:0]  delay;
    logic [mstt_pkg::DELAY_W-1:0]  period;

    modport source (output valid, action, slot_id, delay, period, input ready);
    modport sink   (input valid, action, slot_id, delay, period, output ready);
endinterface

>>> hdl/mstt_out_if.sv
// ----------------------------------------------------------------------------
// mstt_out_if
// Valid/ready channel that carries one acknowledgement or fire event item.
// ----------------------------------------------------------------------------
interface mstt_out_if;
    logic                        valid;
    logic                        ready;
    logic [mstt_pkg::SLOT_W-1:0] slot_out;
    logic                        fired;
    logic                        status;
    logic                        last;

    modport source (output valid, slot_out, fired, status, last, input ready);
    modport sink   (input valid, slot_out, fired, status, last, output ready);
endinterface

>>> hdl/multi_slot_timer_table_top.sv
// A table of eight timer slots behind a 32-bit tick counter. Load, start,
// stop and tick items each return one acknowledgement item, which sits in an
// output register, so the next item is taken while it waits. A single shared
// deadline comparator walks the slots one per cycle, then fire events leave
// in newest-started-first order, one at a time and only while the output is
// not stalled; no new item is taken until the scan is done. A scan with
// nothing due returns no item.

// ----------------------------------------------------------------------------
// multi_slot_timer_table_top
// Top level of the timer slot table: controller plus datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_slot_timer_table_top (
    input  logic      clk,
    input  logic      rst_n,
    mstt_in_if.sink   in_ch,
    mstt_out_if.source out_ch
);

    mstt_pkg::cmd_t      cmd;
    mstt_pkg::stat_t     stat;
    mstt_pkg::state_t    state;
    mstt_pkg::in_item_t  in_item;
    mstt_pkg::out_item_t out_item;
    logic                in_ready;
    logic                out_valid;

    assign in_item.action  = in_ch.action;
    assign in_item.slot_id = in_ch.slot_id;
    assign in_item.delay   = in_ch.delay;
    assign in_item.period  = in_ch.period;
    assign in_ch.ready     = in_ready;

    mstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    mstt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign out_ch.valid    = out_valid;
    assign out_ch.slot_out = out_item.slot_out;
    assign out_ch.fired    = out_item.fired;
    assign out_ch.status   = out_item.status;
    assign out_ch.last     = out_item.last;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    `ASSERT_IMPLIES(a_fire_ok, clk, rst_n, out_ch.valid && out_ch.fired, out_ch.status == mstt_pkg::STATUS_OK)
    `ASSERT_NEXT(a_scan_done_idle, clk, rst_n, (state == mstt_pkg::ST_EMIT) && !stat.mask_any, in_ch.ready)

endmodule

>>> hdl/mstt_ctrl.sv
// ----------------------------------------------------------------------------
// mstt_ctrl
// Controller state machine: sequences accept, execute, compare and emit.
// ----------------------------------------------------------------------------
module mstt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mstt_pkg::stat_t   stat,
    output mstt_pkg::cmd_t    cmd,
    output mstt_pkg::state_t  state
);

    mstt_pkg::state_t state_reg;
    mstt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mstt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mstt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mstt_pkg::ST_EXEC;
                end
            end
            mstt_pkg::ST_EXEC:
            begin
                if (stat.is_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = mstt_pkg::ST_CMP;
                end
                else if (stat.is_ack)
                begin
                    if (stat.out_free)
                    begin
                        cmd.ack    = 1'b1;
                        state_next = mstt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // Unknown actions are dropped without a result.
                    state_next = mstt_pkg::ST_IDLE;
                end
            end
            mstt_pkg::ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (stat.cmp_done)
                begin
                    state_next = mstt_pkg::ST_EMIT;
                end
            end
            mstt_pkg::ST_EMIT:
            begin
                if (!stat.mask_any)
                begin
                    state_next = mstt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.emit_step = 1'b1;
                end
            end
            default:
            begin
                state_next = mstt_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

>>> hdl/mstt_dp.sv
// ----------------------------------------------------------------------------
// mstt_dp
// Datapath: slot tables, tick counter, shared adder and deadline comparator,
// start-order ranks and the output register.
// ----------------------------------------------------------------------------
module mstt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mstt_pkg::in_item_t  in_item,
    input  logic                out_ready,
    output logic                out_valid,
    output mstt_pkg::out_item_t out_item,
    input  mstt_pkg::cmd_t      cmd,
    output mstt_pkg::stat_t     stat
);

    localparam int SLOTS = mstt_pkg::SLOTS;
    localparam int IDX_W = mstt_pkg::IDX_W;
    localparam int TW    = mstt_pkg::TICK_WIDTH;

    mstt_pkg::in_item_t  item_reg, item_next;
    mstt_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    mstt_pkg::tick_t tick_reg, tick_next;
    mstt_pkg::tick_t deadline_reg [SLOTS];
    mstt_pkg::tick_t deadline_next [SLOTS];
    logic [mstt_pkg::DELAY_W-1:0] period_reg [SLOTS];
    logic [mstt_pkg::DELAY_W-1:0] period_next [SLOTS];
    logic [SLOTS-1:0] running_reg, running_next;
    mstt_pkg::idx_t   rank_reg [SLOTS];
    mstt_pkg::idx_t   rank_next [SLOTS];

    // Scan working state: ranks frozen at scan start fix the visiting order.
    mstt_pkg::idx_t   snap_rank_reg [SLOTS];
    mstt_pkg::idx_t   snap_rank_next [SLOTS];
    logic [SLOTS-1:0] fire_mask_reg, fire_mask_next;
    mstt_pkg::idx_t   idx_reg, idx_next;
    mstt_pkg::idx_t   rank_ptr_reg, rank_ptr_next;

    mstt_pkg::idx_t   s_idx;
    logic             s_valid;
    logic [SLOTS-1:0] hit;
    logic             hit_any;
    mstt_pkg::idx_t   emit_slot;
    logic [mstt_pkg::DELAY_W-1:0] add_b;
    mstt_pkg::tick_t  sum;
    logic             cmp_ge;
    logic             out_free;

    logic             idle_en, run_en;
    mstt_pkg::idx_t   idle_tgt, run_tgt;

    assign s_idx    = IDX_W'(item_reg.slot_id);
    assign s_valid  = 32'(item_reg.slot_id) < SLOTS;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        hit       = '0;
        emit_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i] = fire_mask_reg[i] && (snap_rank_reg[i] == rank_ptr_reg);
            if (hit[i])
            begin
                emit_slot = IDX_W'(i);
            end
        end
    end

    assign hit_any = |hit;

    // One adder serves both load (tick plus delay) and re-arm (tick plus period).
    assign add_b  = (item_reg.action == mstt_pkg::ACT_LOAD) ? item_reg.delay
                                                            : period_reg[emit_slot];
    assign sum    = tick_reg + TW'(add_b);
    assign cmp_ge = tick_reg >= deadline_reg[idx_reg];

    always_comb
    begin
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tick_next      = tick_reg;
        deadline_next  = deadline_reg;
        period_next    = period_reg;
        snap_rank_next = snap_rank_reg;
        fire_mask_next = fire_mask_reg;
        idx_next       = idx_reg;
        rank_ptr_next  = rank_ptr_reg;
        idle_en        = 1'b0;
        idle_tgt       = s_idx;
        run_en         = 1'b0;
        run_tgt        = s_idx;

        if (cmd.capture)
        begin
            item_next = in_item;
        end

        if (cmd.ack)
        begin
            out_valid_next    = 1'b1;
            out_next.slot_out = item_reg.slot_id;
            out_next.fired    = 1'b0;
            out_next.status   = mstt_pkg::STATUS_OK;
            out_next.last     = 1'b1;
            unique case (item_reg.action)
                mstt_pkg::ACT_LOAD:
                begin
                    if (s_valid)
                    begin
                        deadline_next[s_idx] = sum;
                        period_next[s_idx]   = item_reg.period;
                    end
                end
                mstt_pkg::ACT_START:
                begin
                    if (s_valid)
                    begin
                        if (running_reg[s_idx])
                        begin
                            out_next.status = mstt_pkg::STATUS_BUSY;
                        end
                        else
                        begin
                            run_en = 1'b1;
                        end
                    end
                end
                mstt_pkg::ACT_STOP:
                begin
                    idle_en = s_valid;
                end
                mstt_pkg::ACT_TICK:
                begin
                    tick_next         = tick_reg + TW'(1);
                    out_next.slot_out = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_start)
        begin
            idx_next       = '0;
            fire_mask_next = '0;
            snap_rank_next = rank_reg;
            rank_ptr_next  = '0;
        end

        if (cmd.cmp_step)
        begin
            fire_mask_next[idx_reg] = running_reg[idx_reg] && cmp_ge;
            idx_next                = idx_reg + IDX_W'(1);
        end

        if (cmd.emit_step)
        begin
            if (!hit_any)
            begin
                rank_ptr_next = rank_ptr_reg + IDX_W'(1);
            end
            else if (out_free)
            begin
                fire_mask_next[emit_slot] = 1'b0;
                out_valid_next    = 1'b1;
                out_next.slot_out = mstt_pkg::SLOT_W'(emit_slot);
                out_next.fired    = 1'b1;
                out_next.status   = mstt_pkg::STATUS_OK;
                out_next.last     = (fire_mask_reg & ~hit) == '0;
                if (period_reg[emit_slot] == '0)
                begin
                    idle_en  = 1'b1;
                    idle_tgt = emit_slot;
                end
                else
                begin
                    deadline_next[emit_slot] = sum;
                end
                rank_ptr_next = rank_ptr_reg + IDX_W'(1);
            end
        end
    end

    // Start-order ranks: rank 0 is the newest running slot, no gaps.
    always_comb
    begin
        running_next = running_reg;
        rank_next    = rank_reg;
        if (idle_en && running_reg[idle_tgt])
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (running_reg[i] && (rank_reg[i] > rank_reg[idle_tgt]))
                begin
                    rank_next[i] = rank_reg[i] - IDX_W'(1);
                end
            end
            running_next[idle_tgt] = 1'b0;
            rank_next[idle_tgt]    = '0;
        end
        if (run_en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (running_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            running_next[run_tgt] = 1'b1;
            rank_next[run_tgt]    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            running_reg   <= '0;
            fire_mask_reg <= '0;
            idx_reg       <= '0;
            rank_ptr_reg  <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                deadline_reg[i] <= '0;
                period_reg[i]   <= '0;
                rank_reg[i]     <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tick_reg      <= tick_next;
            running_reg   <= running_next;
            fire_mask_reg <= fire_mask_next;
            idx_reg       <= idx_next;
            rank_ptr_reg  <= rank_ptr_next;
            deadline_reg  <= deadline_next;
            period_reg    <= period_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        out_reg       <= out_next;
        snap_rank_reg <= snap_rank_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign stat.is_ack   = (item_reg.action == mstt_pkg::ACT_LOAD)
                        || (item_reg.action == mstt_pkg::ACT_START)
                        || (item_reg.action == mstt_pkg::ACT_STOP)
                        || (item_reg.action == mstt_pkg::ACT_TICK);
    assign stat.is_scan  = item_reg.action == mstt_pkg::ACT_SCAN;
    assign stat.out_free = out_free;
    assign stat.cmp_done = idx_reg == IDX_W'(SLOTS - 1);
    assign stat.mask_any = |fire_mask_reg;

endmodule

>>> tb/sv/mstt_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_timer_checker
// Watches both channels of the timer table, keeps its own copy of the slot
// table and tick counter, and compares every result item with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module mstt_timer_checker (
    input  logic clk,
    input  logic rst_n,
    mstt_in_if   in_ch,
    mstt_out_if  out_ch,
    output int   mismatches,
    output int   outstanding
);

    mstt_pkg::tick_t     cur_tick;
    mstt_pkg::tick_t     slot_deadline [mstt_pkg::SLOTS];
    mstt_pkg::tick_t     slot_period   [mstt_pkg::SLOTS];
    logic                slot_running  [mstt_pkg::SLOTS];
    mstt_pkg::idx_t      slot_rank     [mstt_pkg::SLOTS];
    mstt_pkg::out_item_t replies_due [$];
    mstt_pkg::in_item_t  action_seen;
    mstt_pkg::out_item_t reply_exp;
    string               exp_text;
    string               got_text;

    // Removing a slot closes the gap it leaves in the start ranks.
    function automatic void retire_slot(mstt_pkg::idx_t s);
        if (!slot_running[s])
            return;
        for (int i = 0; i < mstt_pkg::SLOTS; i++)
            if (slot_running[i] && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        slot_running[s] = 1'b0;
        slot_rank[s]    = '0;
    endfunction

    function automatic void apply_action(mstt_pkg::in_item_t it);
        mstt_pkg::out_item_t ack;
        mstt_pkg::out_item_t ev;
        mstt_pkg::out_item_t fires [$];
        mstt_pkg::idx_t      visit [$];
        mstt_pkg::idx_t      s;
        s            = mstt_pkg::idx_t'(it.slot_id);
        ack.slot_out = it.slot_id;
        ack.fired    = 1'b0;
        ack.status   = mstt_pkg::STATUS_OK;
        ack.last     = 1'b1;
        case (it.action)
            mstt_pkg::ACT_LOAD:
            begin
                slot_deadline[s] = cur_tick + it.delay;
                slot_period[s]   = it.period;
            end
            mstt_pkg::ACT_START:
            begin
                if (slot_running[s])
                    ack.status = mstt_pkg::STATUS_BUSY;
                else
                begin
                    for (int i = 0; i < mstt_pkg::SLOTS; i++)
                        if (slot_running[i])
                            slot_rank[i]++;
                    slot_running[s] = 1'b1;
                    slot_rank[s]    = '0;
                end
            end
            mstt_pkg::ACT_STOP:
                retire_slot(s);
            mstt_pkg::ACT_TICK:
            begin
                cur_tick     = cur_tick + mstt_pkg::TICK_WIDTH'(1);
                ack.slot_out = '0;
            end
            mstt_pkg::ACT_SCAN:
            begin
                // The visiting order is frozen before any slot is touched.
                for (int r = 0; r < mstt_pkg::SLOTS; r++)
                    for (int i = 0; i < mstt_pkg::SLOTS; i++)
                        if (slot_running[i] && slot_rank[i] == r)
                            visit.push_back(mstt_pkg::idx_t'(i));
                foreach (visit[k])
                begin
                    if (!slot_running[visit[k]] || cur_tick < slot_deadline[visit[k]])
                        continue;
                    if (slot_period[visit[k]] == '0)
                        retire_slot(visit[k]);
                    else
                        slot_deadline[visit[k]] = cur_tick + slot_period[visit[k]];
                    ev.slot_out = mstt_pkg::SLOT_W'(visit[k]);
                    ev.fired    = 1'b1;
                    ev.status   = mstt_pkg::STATUS_OK;
                    ev.last     = 1'b0;
                    fires.push_back(ev);
                end
                foreach (fires[k])
                begin
                    ev      = fires[k];
                    ev.last = (k == fires.size() - 1);
                    replies_due.push_back(ev);
                end
            end
            default:
                ;
        endcase
        if (it.action inside {mstt_pkg::ACT_LOAD, mstt_pkg::ACT_START,
                              mstt_pkg::ACT_STOP, mstt_pkg::ACT_TICK})
            replies_due.push_back(ack);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cur_tick    = '0;
            mismatches  = 0;
            replies_due.delete();
            for (int i = 0; i < mstt_pkg::SLOTS; i++)
            begin
                slot_deadline[i] = '0;
                slot_period[i]   = '0;
                slot_running[i]  = 1'b0;
                slot_rank[i]     = '0;
            end
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got_text = $sformatf("slot_out %0d fired %0b status %0b last %0b",
                                     out_ch.slot_out, out_ch.fired, out_ch.status,
                                     out_ch.last);
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %s",
                             $time, got_text);
                end
                else
                begin
                    reply_exp = replies_due.pop_front();
                    if (reply_exp.slot_out != out_ch.slot_out ||
                        reply_exp.fired    != out_ch.fired    ||
                        reply_exp.status   != out_ch.status   ||
                        reply_exp.last     != out_ch.last)
                    begin
                        mismatches++;
                        exp_text = $sformatf("slot_out %0d fired %0b status %0b last %0b",
                                             reply_exp.slot_out, reply_exp.fired,
                                             reply_exp.status, reply_exp.last);
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, exp_text, got_text);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                action_seen.action  = in_ch.action;
                action_seen.slot_id = in_ch.slot_id;
                action_seen.delay   = in_ch.delay;
                action_seen.period  = in_ch.period;
                apply_action(action_seen);
            end
        end
        outstanding = replies_due.size();
    end

endmodule

>>> tb/sv/multi_slot_timer_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_timer_table_top_test
// Drives load, start, stop, tick and scan items into the timer table under
// several idle and stall patterns, with a long output hold-off, and reports
// the verdict of the channel checker.
// ----------------------------------------------------------------------------
module multi_slot_timer_table_top_test;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_ITEMS     = 370;
    localparam int SETTLE_CYCLES    = 32;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [mstt_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = mstt_pkg::ACT_SCAN + 1'b1;
    localparam logic [mstt_pkg::ACT_W-1:0] ACT_RESERVED_MID   = 3'd6;
    localparam logic [mstt_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   hold_request = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   cycle_count  = 0;
    int   actions_sent;
    int   mismatches;
    int   outstanding;
    bit   counted;

    mstt_in_if  in_ch ();
    mstt_out_if out_ch ();

    multi_slot_timer_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mstt_timer_checker timer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_slot_timer_table_top test failed");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic offer_action(input logic [mstt_pkg::ACT_W-1:0] act,
                                input logic [mstt_pkg::SLOT_W-1:0] slot,
                                input logic [mstt_pkg::DELAY_W-1:0] dly,
                                input logic [mstt_pkg::DELAY_W-1:0] per);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.slot_id <= slot;
        in_ch.delay   <= dly;
        in_ch.period  <= per;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly short delays and periods so that timers keep expiring while the
    // tick count is still small; now and then a full-range value.
    task automatic offer_random_action(output bit useful);
        int                           pick;
        int                           shape;
        logic [mstt_pkg::ACT_W-1:0]   act;
        logic [mstt_pkg::DELAY_W-1:0] dly;
        logic [mstt_pkg::DELAY_W-1:0] per;
        pick  = $urandom_range(99);
        shape = $urandom_range(9);
        dly   = $urandom;
        per   = $urandom;
        useful = 1'b1;
        if (pick < 3)
        begin
            act    = mstt_pkg::ACT_W'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
            useful = 1'b0;
        end
        else if (pick < 28)
        begin
            act = mstt_pkg::ACT_LOAD;
            if ($urandom_range(9) != 0)
                dly = $urandom_range(12);
            if (shape < 3)
                per = '0;
            else if (shape < 9)
                per = $urandom_range(6, 1);
        end
        else if (pick < 46)
            act = mstt_pkg::ACT_START;
        else if (pick < 56)
            act = mstt_pkg::ACT_STOP;
        else if (pick < 80)
            act = mstt_pkg::ACT_TICK;
        else
            act = mstt_pkg::ACT_SCAN;
        offer_action(act, mstt_pkg::SLOT_W'($urandom_range(mstt_pkg::SLOTS - 1)), dly, per);
    endtask

    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.action  = mstt_pkg::ACT_LOAD;
        in_ch.slot_id = '0;
        in_ch.delay   = '0;
        in_ch.period  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A scan on an empty table, a one-shot due at once, a full-range
        // periodic slot whose deadline wraps, a refused start, a stop of an
        // idle slot, a reload of a running slot and the unused action codes.
        offer_action(mstt_pkg::ACT_SCAN,  3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_action(mstt_pkg::ACT_TICK,  3'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        offer_action(mstt_pkg::ACT_LOAD,  3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_LOAD,  3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_action(mstt_pkg::ACT_LOAD,  3'd3, 32'd2, 32'd3);
        offer_action(mstt_pkg::ACT_START, 3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_START, 3'd7, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_START, 3'd3, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_START, 3'd3, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_STOP,  3'd5, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_SCAN,  3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_TICK,  3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_TICK,  3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_LOAD,  3'd3, 32'd0, 32'd1);
        offer_action(mstt_pkg::ACT_SCAN,  3'd0, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_STOP,  3'd7, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_STOP,  3'd7, 32'd0, 32'd0);
        offer_action(ACT_RESERVED_FIRST, 3'd1, 32'd1, 32'd1);
        offer_action(ACT_RESERVED_MID, 3'd2, 32'd2, 32'd2);
        offer_action(ACT_RESERVED_LAST, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_action(mstt_pkg::ACT_LOAD,  3'd4, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_START, 3'd4, 32'd0, 32'd0);
        offer_action(mstt_pkg::ACT_SCAN,  3'd0, 32'd0, 32'd0);
        wait_until_drained();

        actions_sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            // In the first phase the output is held off while items keep coming,
            // so the table backs up and stalls its input.
            if (phase == 0)
                hold_request++;
            while (actions_sent < (RANDOM_ITEMS * (phase + 1)) / 4)
            begin
                offer_random_action(counted);
                if (counted)
                    actions_sent++;
            end
            wait_until_drained();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("multi_slot_timer_table_top test passed");
        else
            $display("multi_slot_timer_table_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mstt_pkg.sv
hdl/mstt_in_if.sv
hdl/mstt_out_if.sv
hdl/mstt_ctrl.sv
hdl/mstt_dp.sv
hdl/multi_slot_timer_table_top.sv
tb/sv/mstt_timer_checker.sv
tb/sv/multi_slot_timer_table_top_test.sv
